>>> rtl/signed_int_to_decimal_ascii_top_macros.svh
// assertion macros for the signed integer to decimal ascii block
// expects clk and rst_n in the scope of the including module
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// same-cycle implication
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sitoa_pkg.sv
// shared types, constants and elaboration helpers for the decimal ascii block
// no dependencies
package sitoa_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam int         RADIX       = 10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  // decimal digits needed for 2^(bits-1)
  function automatic int num_digits(input int bits);
    logic [127:0] lim;
    logic [127:0] p;
    int           n;
    lim = 128'd1 << (bits - 1);
    p   = 128'(RADIX);
    n   = 1;
    for (int k = 0; k < 40; k++) begin
      if (p <= lim) begin
        n = n + 1;
        p = p * 128'(RADIX);
      end
    end
    return n;
  endfunction

endpackage

>>> rtl/signed_int_to_decimal_ascii_top.sv
// signed integer to decimal ascii converter, top level
// depends on sitoa_pkg, sitoa_dabble_step and signed_int_to_decimal_ascii_top_macros.svh
//
// usage:
//   in_value is a two's complement integer of VALUE_BITS bits, taken in one
//   transaction on in_valid/in_ready. its decimal text leaves on
//   out_valid/out_ready as one ascii byte per transaction, most significant
//   first: '-' for a negative value, then the digits without leading zeros,
//   '0' for zero. out_last marks the final byte of each number.
// timing:
//   the magnitude is converted to bcd by a shift-add-3 unit, one bit a cycle;
//   leading zero digits are then dropped one a cycle. the first byte is
//   registered after that, then one byte a cycle leaves while out_ready is
//   high. one number at a time: in_ready is high only when idle, so a new
//   number is taken only after the last byte of the one before is sent.
// reset and stalls:
//   synchronous reset returns to idle and drops out_valid. a low out_ready
//   holds the current byte and the block until it is taken.
`include "signed_int_to_decimal_ascii_top_macros.svh"

module signed_int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [7:0]            out_character,
  output logic                         out_last
);

  localparam int DIGITS = sitoa_pkg::num_digits(VALUE_BITS);
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int DL_W   = $clog2(DIGITS + 1);

  sitoa_pkg::state_t     state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DL_W-1:0]       dl_r, dl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] in_bits;
  logic [VALUE_BITS-1:0] in_mag;
  logic [BCD_W-1:0]      step_bcd;
  logic [3:0]            top_nib;
  logic [BCD_W-1:0]      bcd_shift;
  logic [7:0]            digit_char;
  logic                  in_fire;
  logic                  out_fire;
  logic                  minus_out;

  sitoa_dabble_step #(
    .DIGITS (DIGITS)
  ) u_step (
    .bcd_i (bcd_r),
    .bit_i (mag_r[VALUE_BITS-1]),
    .bcd_o (step_bcd)
  );

  assign in_bits    = in_value;
  assign in_mag     = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;
  assign top_nib    = bcd_r[BCD_W-1 -: 4];
  assign bcd_shift  = {bcd_r[BCD_W-5:0], 4'b0000};
  assign digit_char = sitoa_pkg::ASCII_ZERO + {4'b0000, top_nib};
  assign in_ready   = (state_r == sitoa_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign minus_out  = out_valid_r && (out_char_r == sitoa_pkg::ASCII_MINUS);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dl_nxt        = dl_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      sitoa_pkg::ST_IDLE: begin
        if (in_fire) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_bits[VALUE_BITS-1];
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = sitoa_pkg::ST_CONV;
        end
      end
      sitoa_pkg::ST_CONV: begin
        bcd_nxt = step_bcd;
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          dl_nxt    = DL_W'(DIGITS);
          state_nxt = sitoa_pkg::ST_SKIP;
        end
      end
      sitoa_pkg::ST_SKIP: begin
        if (top_nib == 4'd0 && dl_r != DL_W'(1)) begin
          bcd_nxt = bcd_shift;
          dl_nxt  = dl_r - 1'b1;
        end else begin
          state_nxt     = sitoa_pkg::ST_EMIT;
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = sitoa_pkg::ASCII_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = digit_char;
            out_last_nxt = (dl_r == DL_W'(1));
            bcd_nxt      = bcd_shift;
            dl_nxt       = dl_r - 1'b1;
          end
        end
      end
      sitoa_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (dl_r == '0) begin
            out_valid_nxt = 1'b0;
            state_nxt     = sitoa_pkg::ST_IDLE;
          end else begin
            out_char_nxt = digit_char;
            out_last_nxt = (dl_r == DL_W'(1));
            bcd_nxt      = bcd_shift;
            dl_nxt       = dl_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt     = sitoa_pkg::ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sitoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    dl_r       <= dl_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  `SITOA_ASSERT_NOW(a_idle_no_output, in_ready, !out_valid, "output valid while idle")
  `SITOA_ASSERT_NEXT(a_last_to_idle, out_fire && out_last, in_ready, "no return to idle after last")
  `SITOA_ASSERT_NOW(a_minus_not_last, minus_out, !out_last, "minus sign flagged last")
  `SITOA_ASSERT_NEXT(a_busy_after_input, in_fire, !in_ready, "ready held after input transaction")

endmodule

>>> rtl/sitoa_dabble_step.sv
// one shift-add-3 step of the binary to bcd conversion
// no dependencies
module sitoa_dabble_step #(
  parameter int DIGITS = 10
) (
  input  logic [4*DIGITS-1:0] bcd_i,
  input  logic                bit_i,
  output logic [4*DIGITS-1:0] bcd_o
);

  logic [4*DIGITS-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
  end

  assign bcd_o = {adj[4*DIGITS-2:0], bit_i};

endmodule

>>> verif/signed_int_to_decimal_ascii_top_tb.sv
// self-checking testbench for signed_int_to_decimal_ascii_top: feeds integers, predicts their
// decimal ascii text and checks every output character and last flag in order
// depends on sitoa_pkg and the rtl of the top level
module signed_int_to_decimal_ascii_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_BITS   = 32;
  localparam int RANDOM_ITEMS = 430;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t  expected_chars[$];
    int unsigned fail_count;

    function void report(string msg);
      fail_count++;
      if (fail_count <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void note_value(logic signed [VALUE_BITS-1:0] value);
      logic signed [63:0] wide;
      logic [63:0]        mag;
      logic [3:0]         digits[$];
      text_char_t         c;
      wide = value;
      mag  = (wide < 0) ? 64'(-wide) : 64'(wide);
      do begin
        digits.push_front(4'(mag % sitoa_pkg::RADIX));
        mag = mag / sitoa_pkg::RADIX;
      end while (mag != 0);
      if (wide < 0) begin
        c.ch   = sitoa_pkg::ASCII_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[k]) begin
        c.ch   = sitoa_pkg::ASCII_ZERO + 8'(digits[k]);
        c.last = (k == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t c;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character %0d last %b", ch, last));
        return;
      end
      c = expected_chars.pop_front();
      if (ch !== c.ch || last !== c.last) begin
        report($sformatf("character mismatch: expected %0d last %b, got %0d last %b",
                         c.ch, c.last, ch, last));
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void close();
      if (expected_chars.size() != 0) begin
        report($sformatf("%0d characters never arrived", expected_chars.size()));
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_character;
  logic                         out_last;

  bit hold_request = 1'b0;
  bit quiet = 1'b0;

  text_scoreboard board = new;

  signed_int_to_decimal_ascii_top #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_value(in_value);
    end
    if (rst_n && out_valid && out_ready) begin
      board.check_char(out_character, out_last);
    end
  end

  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] random_value();
    logic signed [VALUE_BITS-1:0] v;
    longint unsigned              p;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 999);
      3: v = $urandom >> $urandom_range(1, 31);
      4: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * sitoa_pkg::RADIX;
        v = VALUE_BITS'(p - $urandom_range(0, 1));
      end
      default: v = $urandom_range(0, 9);
    endcase
    if ($urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
    int gap;
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if (stall_left == 0 && !quiet && $urandom_range(0, 2) == 0) begin
          stall_left = idle_length();
        end
        out_ready <= (stall_left == 0);
        if (stall_left > 0) begin
          stall_left--;
        end
      end
    end
  end

  initial begin
    int corner[];
    corner = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 101, 1000, 100000,
               1000000000, -1000000000, 1999999999, 2000000000, 2147483647,
               -2147483647, 32'sh80000000, 123456789, -987654321, 7, -5};
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (corner[k]) begin
      send_value(VALUE_BITS'(corner[k]));
    end
    wait_drained();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) begin
        hold_request = 1'b1;
      end
      if (n == 200) begin
        wait_drained();
      end
      quiet = (n >= 260 && n < 330);
      send_value(random_value());
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    board.close();
    if (board.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
